// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the ellipse point generator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge while out of reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// A condition that must never be seen at a clock edge while out of reset.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ----- rtl/elp_pkg.sv -----
// ----------------------------------------------------------------------------
// Ellipse point generator package
// Command codes shared by the front end, the back end and the top level.
// ----------------------------------------------------------------------------
package elp_pkg;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_STEP  = 1'b1
    } func_t;

endpackage

// ----- rtl/elp_front.sv -----
// ----------------------------------------------------------------------------
// Ellipse point generator front end
// Accepts commands and precomputes the squared radii, the initial vertical
// term and the initial error of a start command in a two-stage pipeline.
// ----------------------------------------------------------------------------
module elp_front #(
    parameter int  COORD_BITS = 12,
    parameter type item_t     = logic
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  elp_pkg::func_t        in_func,
    input  logic [COORD_BITS-1:0] in_cx,
    input  logic [COORD_BITS-1:0] in_cy,
    input  logic [COORD_BITS-2:0] in_rx,
    input  logic [COORD_BITS-2:0] in_ry,
    output logic                  push,
    output item_t                 push_item,
    input  logic                  queue_full
);

    localparam int RW   = COORD_BITS - 1;
    localparam int SQ_W = 2 * RW;
    localparam int E_W  = 3 * COORD_BITS + 4;
    localparam int M_W  = 3 * COORD_BITS;

    logic                  en;

    logic                  va_reg;
    elp_pkg::func_t        func_a_reg;
    logic [COORD_BITS-1:0] cx_a_reg;
    logic [COORD_BITS-1:0] cy_a_reg;
    logic [RW-1:0]         ry_a_reg;
    logic [SQ_W-1:0]       a2_a_reg;
    logic [SQ_W-1:0]       b2_a_reg;

    logic                  vb_reg;
    elp_pkg::func_t        func_b_reg;
    logic [COORD_BITS-1:0] cx_b_reg;
    logic [COORD_BITS-1:0] cy_b_reg;
    logic [RW-1:0]         ry_b_reg;
    logic [SQ_W-1:0]       a2_b_reg;
    logic [SQ_W-1:0]       b2_b_reg;
    logic signed [E_W-1:0] ty0_b_reg;

    logic signed [COORD_BITS:0] ry_odd;
    logic signed [M_W-1:0]      ty_prod;

    // The pipeline holds as a whole only when its last stage cannot drain.
    assign en       = !vb_reg || !queue_full;
    assign in_ready = en;
    assign push     = vb_reg && !queue_full;

    // 2*ry - 1, which is -1 for a zero radius.
    assign ry_odd  = $signed({1'b0, ry_a_reg, 1'b0}) - $signed((COORD_BITS + 1)'(1));
    assign ty_prod = $signed({1'b0, a2_a_reg}) * ry_odd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            func_a_reg <= in_func;
            cx_a_reg   <= in_cx;
            cy_a_reg   <= in_cy;
            ry_a_reg   <= in_ry;
            a2_a_reg   <= SQ_W'(in_rx) * SQ_W'(in_rx);
            b2_a_reg   <= SQ_W'(in_ry) * SQ_W'(in_ry);

            func_b_reg <= func_a_reg;
            cx_b_reg   <= cx_a_reg;
            cy_b_reg   <= cy_a_reg;
            ry_b_reg   <= ry_a_reg;
            a2_b_reg   <= a2_a_reg;
            b2_b_reg   <= b2_a_reg;
            ty0_b_reg  <= {{(E_W - M_W){ty_prod[M_W-1]}}, ty_prod};
        end
    end

    always_comb begin
        push_item      = '0;
        push_item.func = func_b_reg;
        push_item.cx   = cx_b_reg;
        push_item.cy   = cy_b_reg;
        push_item.ry   = ry_b_reg;
        push_item.a2   = a2_b_reg;
        push_item.b2   = b2_b_reg;
        push_item.ty0  = ty0_b_reg;
        push_item.e0   = $signed({{(E_W - SQ_W){1'b0}}, b2_b_reg}) - ty0_b_reg;
    end

endmodule

// ----- rtl/elp_queue.sv -----
// ----------------------------------------------------------------------------
// Ellipse point generator command queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module elp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_CLK(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(DEPTH), "queue count exceeds depth")
    `ASSERT_NEVER(a_push_when_full, aclk, aresetn, push && full, "queue written while full")
    `ASSERT_NEVER(a_pop_when_empty, aclk, aresetn, pop && !head_valid, "queue read while empty")

endmodule

// ----- rtl/elp_back.sv -----
// ----------------------------------------------------------------------------
// Ellipse point generator back end
// Walks the first-quadrant arc one pixel per command with incrementally kept
// error terms and registers the mirrored point set for the result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module elp_back #(
    parameter int  COORD_BITS = 12,
    parameter type item_t     = logic
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         head_valid,
    input  item_t                        head_item,
    output logic                         pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COORD_BITS+1:0] m_right_x,
    output logic signed [COORD_BITS+1:0] m_left_x,
    output logic signed [COORD_BITS+1:0] m_upper_y,
    output logic signed [COORD_BITS+1:0] m_lower_y,
    output logic                         m_last
);

    localparam int RW   = COORD_BITS - 1;
    localparam int SQ_W = 2 * RW;
    localparam int E_W  = 3 * COORD_BITS + 4;
    localparam int P_W  = E_W + 2;
    localparam int O_W  = COORD_BITS + 2;
    localparam int Y_W  = COORD_BITS + 1;

    // Walk state.
    logic                  active_reg;
    logic [COORD_BITS-1:0] x_reg;
    logic signed [Y_W-1:0] y_reg;
    logic signed [E_W-1:0] e_reg;
    logic signed [E_W-1:0] tx_reg;
    logic signed [E_W-1:0] ty_reg;
    logic [SQ_W-1:0]       a2_reg;
    logic [SQ_W-1:0]       b2_reg;
    logic [COORD_BITS-1:0] cx_reg;
    logic [COORD_BITS-1:0] cy_reg;

    // Result register.
    logic                  out_valid_reg;
    logic signed [O_W-1:0] right_reg;
    logic signed [O_W-1:0] left_reg;
    logic signed [O_W-1:0] upper_reg;
    logic signed [O_W-1:0] lower_reg;
    logic                  last_reg;

    logic                  is_start;
    logic                  produces;
    logic                  fire;
    logic [COORD_BITS-1:0] cur_x;
    logic signed [Y_W-1:0] cur_y;
    logic signed [E_W-1:0] cur_e;
    logic signed [E_W-1:0] cur_tx;
    logic signed [E_W-1:0] cur_ty;
    logic [SQ_W-1:0]       cur_a2;
    logic [SQ_W-1:0]       cur_b2;
    logic [COORD_BITS-1:0] cur_cx;
    logic [COORD_BITS-1:0] cur_cy;

    logic signed [P_W-1:0] e_twice;
    logic signed [P_W-1:0] probe_n;
    logic signed [P_W-1:0] probe_p;
    logic                  e_neg;
    logic                  e_zero;
    logic                  incx;
    logic                  decy;
    logic                  x_step;
    logic                  fin;
    logic signed [E_W-1:0] twice_a2;
    logic signed [E_W-1:0] twice_b2;
    logic [COORD_BITS-1:0] x_next;
    logic signed [Y_W-1:0] y_next;
    logic signed [E_W-1:0] tx_next;
    logic signed [E_W-1:0] ty_next;
    logic signed [E_W-1:0] e_next;

    assign is_start = (head_item.func == elp_pkg::FUNC_START);
    assign produces = is_start || active_reg;
    // A step while idle is dropped without waiting for the result register.
    assign pop      = head_valid && (!out_valid_reg || m_ready || !produces);
    assign fire     = pop && produces;

    // A start transaction walks from its own freshly computed values.
    always_comb begin
        if (is_start) begin
            cur_x  = '0;
            cur_y  = {2'b00, head_item.ry};
            cur_e  = head_item.e0;
            cur_tx = $signed({{(E_W - SQ_W){1'b0}}, head_item.b2});
            cur_ty = head_item.ty0;
            cur_a2 = head_item.a2;
            cur_b2 = head_item.b2;
            cur_cx = head_item.cx;
            cur_cy = head_item.cy;
        end else begin
            cur_x  = x_reg;
            cur_y  = y_reg;
            cur_e  = e_reg;
            cur_tx = tx_reg;
            cur_ty = ty_reg;
            cur_a2 = a2_reg;
            cur_b2 = b2_reg;
            cur_cx = cx_reg;
            cur_cy = cy_reg;
        end
    end

    // tx holds b2*(2x+1) and ty holds a2*(2y-1) for the current offsets.
    assign e_twice = {cur_e[E_W-1], cur_e, 1'b0};
    assign probe_n = e_twice + {{2{cur_ty[E_W-1]}}, cur_ty};
    assign probe_p = e_twice - {{2{cur_tx[E_W-1]}}, cur_tx};
    assign e_neg   = cur_e[E_W-1];
    assign e_zero  = (cur_e == '0);

    assign incx   = e_neg || e_zero || probe_p[P_W-1];
    assign decy   = !e_neg || (!probe_n[P_W-1] && (probe_n != '0));
    assign x_step = incx && !(&cur_x);
    assign fin    = decy && (cur_y == '0);

    assign twice_a2 = $signed({{(E_W - SQ_W - 1){1'b0}}, cur_a2, 1'b0});
    assign twice_b2 = $signed({{(E_W - SQ_W - 1){1'b0}}, cur_b2, 1'b0});

    assign x_next  = x_step ? cur_x + 1'b1 : cur_x;
    assign y_next  = decy ? cur_y - $signed(Y_W'(1)) : cur_y;
    assign tx_next = x_step ? cur_tx + twice_b2 : cur_tx;
    assign ty_next = decy ? cur_ty - twice_a2 : cur_ty;
    assign e_next  = cur_e + (incx ? tx_next : '0) - (decy ? ty_next : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                active_reg    <= !fin;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            e_reg     <= e_next;
            tx_reg    <= tx_next;
            ty_reg    <= ty_next;
            a2_reg    <= cur_a2;
            b2_reg    <= cur_b2;
            cx_reg    <= cur_cx;
            cy_reg    <= cur_cy;
            right_reg <= $signed({2'b00, cur_cx}) + $signed({2'b00, cur_x});
            left_reg  <= $signed({2'b00, cur_cx}) - $signed({2'b00, cur_x});
            upper_reg <= $signed({2'b00, cur_cy}) + $signed({cur_y[Y_W-1], cur_y});
            lower_reg <= $signed({2'b00, cur_cy}) - $signed({cur_y[Y_W-1], cur_y});
            last_reg  <= fin;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_right_x = right_reg;
    assign m_left_x  = left_reg;
    assign m_upper_y = upper_reg;
    assign m_lower_y = lower_reg;
    assign m_last    = last_reg;

    `ASSERT_CLK(a_active_y_nonneg, aclk, aresetn, active_reg |-> !y_reg[Y_W-1], "y offset negative while active")
    `ASSERT_CLK(a_last_goes_idle, aclk, aresetn, (fire && fin) |=> !active_reg, "walk still active after last set")
    `ASSERT_CLK(a_last_only_valid, aclk, aresetn, (fire && fin) |=> (m_valid && m_last), "last set not presented")

endmodule

// ----- rtl/ellipse_point_generator.sv -----
// ----------------------------------------------------------------------------
// Ellipse point generator
// Bresenham rasterizer for axis-aligned ellipses, four mirrored points a set.
// ----------------------------------------------------------------------------
// Usage:
// A command transaction on the s_ channel either starts an ellipse (s_func
// low: center and radii are taken) or advances one pixel step (s_func high).
// Every start, and every step while an arc is in progress, returns one point
// set on the m_ channel: right/left x and upper/lower y about the center.
// m_last marks the set after which y would go negative; the block is then
// idle and further steps return nothing until the next start.
// From an accepted command to m_valid: two front stages compute the squared
// radii and the initial error terms, the queue holds the command, then the
// back end walks one step and registers the result.
// Throughput is one command per cycle while the receiver is ready; the walk
// loop is all adds on terms kept incrementally. A stalled receiver holds the
// result register, the queue absorbs commands behind it, and s_ready drops
// once the queue is full and the last front stage holds a command.
// Reset (synchronous, active low) empties the queue and leaves the block idle.
// ----------------------------------------------------------------------------
module ellipse_point_generator #(
    parameter int COORD_BITS  = 12,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_func,
    input  logic [COORD_BITS-1:0]        s_center_x,
    input  logic [COORD_BITS-1:0]        s_center_y,
    input  logic [COORD_BITS-2:0]        s_radius_x,
    input  logic [COORD_BITS-2:0]        s_radius_y,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COORD_BITS+1:0] m_right_x,
    output logic signed [COORD_BITS+1:0] m_left_x,
    output logic signed [COORD_BITS+1:0] m_upper_y,
    output logic signed [COORD_BITS+1:0] m_lower_y,
    output logic                         m_last
);

    localparam int RW   = COORD_BITS - 1;
    localparam int SQ_W = 2 * RW;
    localparam int E_W  = 3 * COORD_BITS + 4;

    typedef struct packed {
        elp_pkg::func_t        func;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [RW-1:0]         ry;
        logic [SQ_W-1:0]       a2;
        logic [SQ_W-1:0]       b2;
        logic signed [E_W-1:0] ty0;
        logic signed [E_W-1:0] e0;
    } item_t;

    logic  push;
    item_t push_item;
    logic  queue_full;
    logic  pop;
    logic  head_valid;
    item_t head_item;

    elp_front #(
        .COORD_BITS (COORD_BITS),
        .item_t     (item_t)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_func    (elp_pkg::func_t'(s_func)),
        .in_cx      (s_center_x),
        .in_cy      (s_center_y),
        .in_rx      (s_radius_x),
        .in_ry      (s_radius_y),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    elp_queue #(
        .WIDTH (($bits(item_t))),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_item)
    );

    elp_back #(
        .COORD_BITS (COORD_BITS),
        .item_t     (item_t)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_right_x  (m_right_x),
        .m_left_x   (m_left_x),
        .m_upper_y  (m_upper_y),
        .m_lower_y  (m_lower_y),
        .m_last     (m_last)
    );

endmodule
